// ===== src/four_tap_resampling_interpolator_core_assert.svh =====
// Assertion macros shared by the interpolator RTL.
`ifndef FOUR_TAP_RESAMPLING_INTERPOLATOR_CORE_ASSERT_SVH
`define FOUR_TAP_RESAMPLING_INTERPOLATOR_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clock, disabled in reset.
`define FTRI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clock, disabled in reset.
`define FTRI_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ftri_pkg.sv =====
// Shared constants, mode codes and weight helpers for the interpolator.
`default_nettype none
package ftri_pkg;

   localparam logic [2:0] MODE_NONE    = 3'd0;
   localparam logic [2:0] MODE_ROUND   = 3'd1;
   localparam logic [2:0] MODE_LINEAR  = 3'd2;
   localparam logic [2:0] MODE_KEYS    = 3'd3;
   localparam logic [2:0] MODE_BSPLINE = 3'd4;
   localparam logic [2:0] MODE_OMOMS   = 3'd5;
   localparam logic [2:0] MODE_IDW     = 3'd6;
   localparam logic [2:0] MODE_RESET   = MODE_LINEAR;

   localparam logic [1:0] TAP_PREV  = 2'd0;
   localparam logic [1:0] TAP_BASE  = 2'd1;
   localparam logic [1:0] TAP_NEXT  = 2'd2;
   localparam logic [1:0] TAP_AFTER = 2'd3;

   localparam int NUM_TAPS    = 4;
   localparam int WEIGHT_BITS = 36;
   localparam int NUM_BITS    = 41;
   localparam int DIV42_W     = 38;
   localparam int RECIP_W     = 65;
   localparam int SQ_STAGES   = 4;
   localparam int POLY_LAT    = 5;
   localparam int MERGE_LAT   = 4;

   // ceil(2^44 / 42): multiply and shift by 44 gives floor(m / 42) for m below 2^38
   localparam logic [38:0] RCP42 = 39'h61_8618_6187;

   localparam logic signed [WEIGHT_BITS-1:0] W_ONE = 36'sh1_0000_0000;

   // Stages from the lane inputs to the registered weight.
   function automatic int lane_latency(input int frac_bits);
      return frac_bits + 2 + 32 + SQ_STAGES + 1 + RECIP_W + 1;
   endfunction

   // Numerator of 42 times the polynomial weight of one tap.
   function automatic logic signed [NUM_BITS-1:0] poly_num(
      input logic [1:0] tap, input logic [2:0] mode,
      input logic [31:0] t, input logic [31:0] t2, input logic [31:0] t3);
      logic signed [NUM_BITS-1:0] a, b, c, one, n;
      a   = $signed({9'b0, t});
      b   = $signed({9'b0, t2});
      c   = $signed({9'b0, t3});
      one = 41'sd4294967296;
      n   = '0;
      case (mode)
         MODE_KEYS: begin
            case (tap)
               TAP_PREV:  n = -21 * c + 42 * b - 21 * a;
               TAP_BASE:  n = 63 * c - 105 * b + 42 * one;
               TAP_NEXT:  n = -63 * c + 84 * b + 21 * a;
               default:   n = 21 * c - 21 * b;
            endcase
         end
         MODE_BSPLINE: begin
            case (tap)
               TAP_PREV:  n = 7 * one - 21 * a + 21 * b - 7 * c;
               TAP_BASE:  n = 28 * one - 42 * b + 21 * c;
               TAP_NEXT:  n = 7 * one + 21 * a + 21 * b - 21 * c;
               default:   n = 7 * c;
            endcase
         end
         MODE_OMOMS: begin
            case (tap)
               TAP_PREV:  n = 8 * one - 22 * a + 21 * b - 7 * c;
               TAP_BASE:  n = 26 * one + 3 * a - 42 * b + 21 * c;
               TAP_NEXT:  n = 8 * one + 18 * a + 21 * b - 21 * c;
               default:   n = a + 7 * c;
            endcase
         end
         default: n = '0;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== src/ftri_if.sv =====
// Request and response stream interfaces of the interpolator.
`default_nettype none
interface ftri_req_if #(parameter int FRAC_BITS = 16, parameter int SAMPLE_BITS = 32);
   logic                          valid;
   logic                          ready;
   logic        [FRAC_BITS-1:0]   frac;
   logic signed [SAMPLE_BITS-1:0] sample_prev;
   logic signed [SAMPLE_BITS-1:0] sample_base;
   logic signed [SAMPLE_BITS-1:0] sample_next;
   logic signed [SAMPLE_BITS-1:0] sample_after;
   modport source (output valid, frac, sample_prev, sample_base, sample_next, sample_after,
                   input ready);
   modport sink (input valid, frac, sample_prev, sample_base, sample_next, sample_after,
                 output ready);
endinterface

interface ftri_rsp_if #(parameter int SAMPLE_BITS = 32);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] value;
   modport source (output valid, value, input ready);
   modport sink (input valid, value, output ready);
endinterface
`default_nettype wire

// ===== src/ftri_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module ftri_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 6
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo
);
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [NUM_W-1:0] quo_ff [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [DEN_W-1:0] rem_p, rem_in;
      logic [NUM_W-1:0] num_p, quo_p;
      logic [DEN_W-1:0] den_p;
      logic [DEN_W:0]   trial, diff;
      logic             ge;
      if (k == 0) begin : g_first
         assign rem_p = '0;
         assign num_p = num;
         assign den_p = den;
         assign quo_p = '0;
      end else begin : g_next
         assign rem_p = rem_ff[k-1];
         assign num_p = num_ff[k-1];
         assign den_p = den_ff[k-1];
         assign quo_p = quo_ff[k-1];
      end
      assign trial  = {rem_p, num_p[NUM_W-1]};
      assign ge     = trial >= {1'b0, den_p};
      assign diff   = trial - {1'b0, den_p};
      assign rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            num_ff[k] <= {num_p[NUM_W-2:0], 1'b0};
            den_ff[k] <= den_p;
            quo_ff[k] <= {quo_p[NUM_W-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[NUM_W-1];
endmodule
`default_nettype wire

// ===== src/ftri_lane.sv =====
// One tap lane: polynomial and inverse-distance weight, mode select.
`default_nettype none
module ftri_lane #(
   parameter int TAP       = 0,
   parameter int FRAC_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic [FRAC_BITS-1:0]                    frac,
   input  logic [2:0]                              mode,
   output logic signed [ftri_pkg::WEIGHT_BITS-1:0] weight
);
   import ftri_pkg::*;

   localparam int AW      = FRAC_BITS + 2;
   localparam int NR      = AW + 32;
   localparam int IDW_LAT = lane_latency(FRAC_BITS) - 1;
   localparam int PAD     = IDW_LAT - POLY_LAT;
   localparam logic [1:0] MY_TAP = 2'(TAP);
   localparam logic [AW-1:0] FONE = AW'(1) << FRAC_BITS;

   // ---- polynomial path ----
   logic [31:0] t;
   logic [63:0] sq_prod, cube_prod;
   logic [31:0] ta_ff, t2a_ff, tb_ff, t2b_ff, t3_ff;
   logic [2:0]  md1_ff, md2_ff;
   logic signed [NUM_BITS-1:0] n, abs_n;
   logic [DIV42_W-1:0] m_ff;
   logic [38:0] phh42_ff, phl42_ff, plh42_ff, pll42_ff;
   logic [77:0] sum42;
   logic [33:0] q42_ff;
   logic neg_ff;
   logic neg_d_ff [2];
   logic signed [WEIGHT_BITS-1:0] wpoly;
   logic signed [WEIGHT_BITS-1:0] wp_ff [PAD];

   assign t         = {frac, {(32-FRAC_BITS){1'b0}}};
   assign sq_prod   = t * t;
   assign cube_prod = t2a_ff * ta_ff;
   assign n         = poly_num(MY_TAP, md2_ff, tb_ff, t2b_ff, t3_ff);
   assign abs_n     = n[NUM_BITS-1] ? -n : n;

   // divide by 42 through the reciprocal, split into 19 by 19 and 19 by 20 bit partial products
   assign sum42 = {phh42_ff, 39'b0} + {20'b0, phl42_ff, 19'b0}
                + {19'b0, plh42_ff, 20'b0} + {39'b0, pll42_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         ta_ff  <= t;
         t2a_ff <= sq_prod[63:32];
         md1_ff <= mode;
         tb_ff  <= ta_ff;
         t2b_ff <= t2a_ff;
         t3_ff  <= cube_prod[63:32];
         md2_ff <= md1_ff;
         m_ff   <= abs_n[DIV42_W-1:0] + DIV42_W'(21);
         neg_ff <= n[NUM_BITS-1];
         phh42_ff <= m_ff[DIV42_W-1:19] * RCP42[38:20];
         phl42_ff <= m_ff[DIV42_W-1:19] * RCP42[19:0];
         plh42_ff <= m_ff[18:0] * RCP42[38:20];
         pll42_ff <= m_ff[18:0] * RCP42[19:0];
         neg_d_ff[0] <= neg_ff;
         q42_ff <= sum42[77:44];
         neg_d_ff[1] <= neg_d_ff[0];
         wp_ff[0] <= wpoly;
         for (int k = 1; k < PAD; k++) wp_ff[k] <= wp_ff[k-1];
      end
   end

   assign wpoly = neg_d_ff[1] ? -$signed({2'b0, q42_ff})
                              :  $signed({2'b0, q42_ff});

   // ---- inverse distance path ----
   logic [AW-1:0] span [NUM_TAPS];
   logic [63:0]   r4_w [NUM_TAPS];
   logic          ov_w [NUM_TAPS];
   logic [65:0]   csum;
   logic [63:0]   c_ff;
   logic          zero_ff;
   logic          zd_ff [RECIP_W];
   logic [RECIP_W-1:0] recip;

   assign span[0] = FONE + AW'(frac);
   assign span[1] = AW'(frac);
   assign span[2] = FONE - AW'(frac);
   assign span[3] = (FONE << 1) - AW'(frac);

   for (genvar j = 0; j < NUM_TAPS; j++) begin : g_ratio
      if (j == TAP) begin : g_self
         assign r4_w[j] = 64'h1_0000_0000;
         assign ov_w[j] = 1'b0;
      end else begin : g_other
         logic [NR-1:0] r_q;
         logic [39:0]   r;
         logic [39:0]   phh_ff, phl_ff, pll_ff;
         logic [80:0]   sum_b;
         logic [47:0]   r2_ff;
         logic [47:0]   qhh_ff, qhl_ff, qll_ff;
         logic [96:0]   sum_d;
         logic [63:0]   r4_ff;
         logic          ova_ff, ovb_ff, ovc_ff, ovd_ff;

         ftri_div #(.NUM_W(NR), .DEN_W(AW)) u_div (
            .clock (clock), .en (en), .num ({span[TAP], 32'b0}), .den (span[j]), .quo (r_q)
         );
         assign r     = r_q[39:0];
         assign sum_b = {1'b0, phh_ff, 40'b0} + {20'b0, phl_ff, 21'b0} + {41'b0, pll_ff};
         assign sum_d = {1'b0, qhh_ff, 48'b0} + {24'b0, qhl_ff, 25'b0} + {49'b0, qll_ff};

         always_ff @(posedge clock) begin
            if (en) begin
               phh_ff <= r[39:20] * r[39:20];
               phl_ff <= r[39:20] * r[19:0];
               pll_ff <= r[19:0] * r[19:0];
               ova_ff <= |r_q[NR-1:40];
               r2_ff  <= sum_b[79:32];
               ovb_ff <= ova_ff;
               qhh_ff <= r2_ff[47:24] * r2_ff[47:24];
               qhl_ff <= r2_ff[47:24] * r2_ff[23:0];
               qll_ff <= r2_ff[23:0] * r2_ff[23:0];
               ovc_ff <= ovb_ff;
               r4_ff  <= sum_d[95:32];
               ovd_ff <= ovc_ff;
            end
         end
         assign r4_w[j] = r4_ff;
         assign ov_w[j] = ovd_ff;
      end
   end

   assign csum = {2'b0, r4_w[0]} + {2'b0, r4_w[1]} + {2'b0, r4_w[2]} + {2'b0, r4_w[3]};

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff    <= csum[63:0];
         zero_ff <= ov_w[0] | ov_w[1] | ov_w[2] | ov_w[3] | (|csum[65:64]);
         zd_ff[0] <= zero_ff;
         for (int k = 1; k < RECIP_W; k++) zd_ff[k] <= zd_ff[k-1];
      end
   end

   // floor(2^64 / c); c is at least 2^32 so the quotient fits 33 bits
   ftri_div #(.NUM_W(RECIP_W), .DEN_W(64)) u_recip (
      .clock (clock), .en (en), .num ({1'b1, 64'b0}), .den (c_ff), .quo (recip)
   );

   // ---- control delay and select ----
   logic [FRAC_BITS-1:0] fd_ff [IDW_LAT];
   logic [2:0]           md_ff [IDW_LAT];
   logic [FRAC_BITS-1:0] fd;
   logic [2:0]           md;
   logic signed [WEIGHT_BITS-1:0] td, weight_in, weight_ff;
   logic [1:0] round_tap;

   always_ff @(posedge clock) begin
      if (en) begin
         fd_ff[0] <= frac;
         md_ff[0] <= mode;
         for (int k = 1; k < IDW_LAT; k++) begin
            fd_ff[k] <= fd_ff[k-1];
            md_ff[k] <= md_ff[k-1];
         end
         weight_ff <= weight_in;
      end
   end

   assign fd        = fd_ff[IDW_LAT-1];
   assign md        = md_ff[IDW_LAT-1];
   assign td        = $signed({4'b0, fd, {(32-FRAC_BITS){1'b0}}});
   assign round_tap = fd[FRAC_BITS-1] ? TAP_NEXT : TAP_BASE;

   always_comb begin
      weight_in = '0;
      if (fd == '0) begin
         weight_in = (MY_TAP == TAP_BASE) ? W_ONE : '0;
      end else begin
         case (md)
            MODE_ROUND:  weight_in = (MY_TAP == round_tap) ? W_ONE : '0;
            MODE_LINEAR: begin
               if (MY_TAP == TAP_BASE) weight_in = W_ONE - td;
               else if (MY_TAP == TAP_NEXT) weight_in = td;
            end
            MODE_KEYS, MODE_BSPLINE, MODE_OMOMS: weight_in = wp_ff[PAD-1];
            MODE_IDW: weight_in = zd_ff[RECIP_W-1] ? '0 : $signed({3'b0, recip[32:0]});
            default:  weight_in = '0;
         endcase
      end
   end

   assign weight = weight_ff;
endmodule
`default_nettype wire

// ===== src/ftri_merge.sv =====
// Weighted sum of the four taps, rounding and saturation.
`default_nettype none
module ftri_merge #(
   parameter int SAMPLE_BITS = 32
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic signed [ftri_pkg::WEIGHT_BITS-1:0] weight [ftri_pkg::NUM_TAPS],
   input  logic signed [SAMPLE_BITS-1:0]           sample [ftri_pkg::NUM_TAPS],
   output logic signed [SAMPLE_BITS-1:0]           value
);
   import ftri_pkg::*;

   localparam int PW = SAMPLE_BITS + WEIGHT_BITS;
   localparam int VW = PW + 2 - 32;
   localparam logic signed [PW+1:0] HALF = $signed({{(PW+1-31){1'b0}}, 1'b1, 31'b0});

   logic signed [SAMPLE_BITS+18:0] ph_ff [NUM_TAPS];
   logic signed [SAMPLE_BITS+17:0] pl_ff [NUM_TAPS];
   logic signed [PW-1:0]           pk_ff [NUM_TAPS];
   logic signed [PW:0]             s01_ff, s23_ff;
   logic signed [PW+1:0]           tot;
   logic signed [VW-1:0]           v;
   logic signed [SAMPLE_BITS-1:0]  sat, value_ff;
   logic                           fits;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NUM_TAPS; k++) begin
            ph_ff[k] <= sample[k] * $signed(weight[k][WEIGHT_BITS-1:17]);
            pl_ff[k] <= sample[k] * $signed({1'b0, weight[k][16:0]});
            pk_ff[k] <= $signed({ph_ff[k], 17'b0}) + PW'(pl_ff[k]);
         end
         s01_ff   <= (PW+1)'(pk_ff[0]) + (PW+1)'(pk_ff[1]);
         s23_ff   <= (PW+1)'(pk_ff[2]) + (PW+1)'(pk_ff[3]);
         value_ff <= sat;
      end
   end

   // round half up, then clamp to the sample range
   assign tot  = (PW+2)'(s01_ff) + (PW+2)'(s23_ff) + HALF;
   assign v    = tot[PW+1:32];
   assign fits = (v[VW-1:SAMPLE_BITS-1] == '0) || (v[VW-1:SAMPLE_BITS-1] == '1);
   assign sat  = fits ? v[SAMPLE_BITS-1:0]
               : (v[VW-1] ? $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}})
                          : $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}}));
   assign value = value_ff;
endmodule
`default_nettype wire

// ===== src/four_tap_resampling_interpolator_core.sv =====
// Top level of the four-tap resampling interpolator.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  req_if   | in        | frac, sample_prev, sample_base, sample_next, sample_after
//  rsp_if   | out       | value
//  csr_*    | in        | mode (write only)
//
// One item enters per cycle while rsp_if is not stalled; the time from accept to result is
// set by the bit-per-stage ratio dividers and reciprocal divider of the inverse-distance
// path, which all modes share for in-order delivery.
// Reset clears the valid chain and sets mode to linear. When rsp_if is stalled the
// whole pipeline holds; the input register still takes an item if it is empty.
`default_nettype none
module four_tap_resampling_interpolator_core #(
   parameter int SAMPLE_BITS = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   ftri_req_if.sink   req_if,
   ftri_rsp_if.source rsp_if,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data
);
   import ftri_pkg::*;

   localparam int LANE_LAT = lane_latency(FRAC_BITS);
   localparam int V_N      = LANE_LAT + MERGE_LAT + 1;

   logic en, ld;
   logic [2:0] mode_ff;
   logic       v_ff [V_N];
   logic       v_in [V_N];

   // input register
   logic [FRAC_BITS-1:0]          frac_ff;
   logic [2:0]                    mode_s0_ff;
   logic signed [SAMPLE_BITS-1:0] samp_ff [NUM_TAPS];
   logic signed [SAMPLE_BITS-1:0] sd_ff [LANE_LAT][NUM_TAPS];
   logic signed [WEIGHT_BITS-1:0] weight [NUM_TAPS];

   // advance when the output slot is free or being taken
   assign en           = !v_ff[V_N-1] || rsp_if.ready;
   // load the input register when it advances or sits empty
   assign ld           = en || !v_ff[0];
   assign req_if.ready = ld;
   assign rsp_if.valid = v_ff[V_N-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   always_comb begin
      for (int k = 0; k < V_N; k++) v_in[k] = v_ff[k];
      if (ld) v_in[0] = req_if.valid;
      if (en) begin
         for (int k = 1; k < V_N; k++) v_in[k] = v_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < V_N; k++) v_ff[k] <= 1'b0;
      end else begin
         for (int k = 0; k < V_N; k++) v_ff[k] <= v_in[k];
      end
   end

   // capture the item; payload needs no reset
   always_ff @(posedge clock) begin
      if (ld) begin
         frac_ff    <= req_if.frac;
         mode_s0_ff <= mode_ff;
         samp_ff[0] <= req_if.sample_prev;
         samp_ff[1] <= req_if.sample_base;
         samp_ff[2] <= req_if.sample_next;
         samp_ff[3] <= req_if.sample_after;
      end
   end

   // carry the samples alongside the lanes
   always_ff @(posedge clock) begin
      if (en) begin
         sd_ff[0] <= samp_ff;
         for (int k = 1; k < LANE_LAT; k++) sd_ff[k] <= sd_ff[k-1];
      end
   end

   for (genvar i = 0; i < NUM_TAPS; i++) begin : g_lane
      ftri_lane #(.TAP(i), .FRAC_BITS(FRAC_BITS)) u_lane (
         .clock  (clock),
         .en     (en),
         .frac   (frac_ff),
         .mode   (mode_s0_ff),
         .weight (weight[i])
      );
   end

   ftri_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
      .clock  (clock),
      .en     (en),
      .weight (weight),
      .sample (sd_ff[LANE_LAT-1]),
      .value  (rsp_if.value)
   );

`include "four_tap_resampling_interpolator_core_assert.svh"

   `FTRI_ASSERT_NXT(a_mode_write, csr_wr_en, $past(reset) || mode_ff == $past(csr_wr_data), "mode register missed a write")
   `FTRI_ASSERT_IMP(a_load_when_free, req_if.valid && req_if.ready && v_ff[0], en, "input register overwritten while held")
   `FTRI_ASSERT_NXT(a_valid_shift, en, $past(reset) || v_ff[1] == $past(v_ff[0]), "valid chain lost an item")

endmodule
`default_nettype wire
